>>> rtl/core/paged_fixed_block_allocator_top_defines.svh
// assertion macros shared by the checker
`ifndef PAGED_FIXED_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define PAGED_FIXED_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define PFBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

   localparam int MAX_PAGES           = 8;
   localparam int MAX_BLOCKS_PER_PAGE = 64;

   localparam int PAGE_W   = $clog2(MAX_PAGES);
   localparam int SLOT_W   = $clog2(MAX_BLOCKS_PER_PAGE);
   localparam int OPEN_W   = $clog2(MAX_PAGES + 1);
   localparam int BPP_W    = 7;
   localparam int BSIZE_W  = 13;
   localparam int OFFSET_W = 18;
   localparam int LINK_W   = SLOT_W + 1;
   localparam int ADDR_W   = PAGE_W + SLOT_W;
   localparam int RAM_DEPTH = MAX_PAGES * MAX_BLOCKS_PER_PAGE;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BLOCKS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = CSR_IDX_W'(1);

   localparam logic [BPP_W-1:0]   BPP_RESET   = BPP_W'(64);
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(16);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // decision for one item, taken on the accept cycle
   typedef struct packed {
      logic              ok;
      logic              pop;
      logic              push;
      logic              fresh;
      logic              open_page;
      logic [PAGE_W-1:0] page;
      logic [SLOT_W-1:0] slot;
      logic [LINK_W-1:0] link;
   } pfba_plan_type;

   // head update after a free-list pop
   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] page;
      logic [LINK_W-1:0] link;
   } pfba_wb_type;

endpackage

`default_nettype wire

>>> rtl/core/paged_fixed_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// paged fixed-size block allocator
// request: a beat is taken when start is high and busy is low; req_opcode picks
//   allocate or free, req_free_page / req_free_slot name the block to free
// response: exactly one beat per request, shown for one cycle with rsp_valid,
//   in the cycle after the request beat; the receiver cannot stall it
// rsp_ok low means no block was available or the freed handle was outside the
//   open pages or past the page size; page, slot and byte_offset are then zero
// busy: a new request is taken only after the response beat; busy stays high for
//   the response cycle, during which a free-list pop takes the next link read from
//   the link ram and writes it back into the page head
// page choice is a combinational priority pick over per-page serve flags
// config: csr_ready is always high; index 0 is the page size in blocks, index 1
//   the block size in bytes, other indexes are dropped; write only while idle
// reset: all pages empty with only page 0 open, config back to 64 blocks per
//   page and 16 bytes per block; the link ram needs no clearing pass
module paged_fixed_block_allocator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_opcode,
   input  wire logic [pfba_pkg::PAGE_W-1:0]       req_free_page,
   input  wire logic [pfba_pkg::SLOT_W-1:0]       req_free_slot,
   // response channel
   output logic                                   rsp_valid,
   output logic                                   rsp_ok,
   output logic      [pfba_pkg::PAGE_W-1:0]       rsp_page,
   output logic      [pfba_pkg::SLOT_W-1:0]       rsp_slot,
   output logic      [pfba_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   // config write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pfba_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type                    state_ff;
   logic                         rsp_valid_ff;
   logic                         ok_ff;
   logic                         pop_ff;
   logic [pfba_pkg::PAGE_W-1:0]  page_ff;
   logic [pfba_pkg::SLOT_W-1:0]  slot_ff;

   logic [pfba_pkg::BPP_W-1:0]   bpp_ff;
   logic [pfba_pkg::BSIZE_W-1:0] bsize_ff;

   logic                         accept;
   pfba_pkg::pfba_plan_type      plan;
   pfba_pkg::pfba_wb_type        wb;
   logic [pfba_pkg::LINK_W-1:0]  link_rd;
   logic [pfba_pkg::SLOT_W+pfba_pkg::BSIZE_W-1:0] offset_full;

   // busy doubles as the interlock: the pop writeback lands before the next scan
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= pfba_pkg::BPP_RESET;
         bsize_ff <= pfba_pkg::BSIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pfba_pkg::CSR_PAGE_BLOCKS: bpp_ff   <= csr_wdata[pfba_pkg::BPP_W-1:0];
            pfba_pkg::CSR_BLOCK_BYTES: bsize_ff <= csr_wdata[pfba_pkg::BSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // per-page heads, fresh counts and open-page count
   pfba_pages u_pages (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_opcode),
      .free_page   (req_free_page),
      .free_slot   (req_free_slot),
      .page_blocks (bpp_ff),
      .wb          (wb),
      .plan        (plan)
   );

   // one link per block: a free writes the old head, a pop reads the next head
   pfba_ram #(
      .WIDTH (pfba_pkg::LINK_W),
      .DEPTH (pfba_pkg::RAM_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (accept && plan.push),
      .rd_en   (accept && plan.pop),
      .addr    ({plan.page, plan.slot}),
      .wr_data (plan.link),
      .rd_data (link_rd)
   );

   // popped page takes the link read back from the ram
   always_comb begin
      wb.valid = (state_ff == ST_RESP) && pop_ff;
      wb.page  = page_ff;
      wb.link  = link_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pop_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
                  pop_ff       <= plan.pop;
                  ok_ff        <= plan.ok;
                  page_ff      <= plan.page;
                  slot_ff      <= plan.slot;
               end
            end
            ST_RESP: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
               pop_ff       <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // slot is zero on a failed beat, so the offset is zero as well
   assign offset_full = (pfba_pkg::SLOT_W + pfba_pkg::BSIZE_W)'(slot_ff) *
                        (pfba_pkg::SLOT_W + pfba_pkg::BSIZE_W)'(bsize_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_page        = page_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_byte_offset = offset_full[pfba_pkg::OFFSET_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/pfba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pfba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/pfba_pages.sv
`timescale 1ns / 1ps
`default_nettype none

module pfba_pages (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          opcode,
   input  wire logic [pfba_pkg::PAGE_W-1:0]   free_page,
   input  wire logic [pfba_pkg::SLOT_W-1:0]   free_slot,
   input  wire logic [pfba_pkg::BPP_W-1:0]    page_blocks,
   input  wire pfba_pkg::pfba_wb_type         wb,
   output pfba_pkg::pfba_plan_type            plan
);

   logic [pfba_pkg::SLOT_W-1:0] head_ff [pfba_pkg::MAX_PAGES];
   logic [pfba_pkg::MAX_PAGES-1:0] head_valid_ff;
   logic [pfba_pkg::BPP_W-1:0]  count_ff [pfba_pkg::MAX_PAGES];
   logic [pfba_pkg::OPEN_W-1:0] open_ff;

   logic [pfba_pkg::BPP_W-1:0]     bpp_eff;
   logic [pfba_pkg::MAX_PAGES-1:0] can_serve;
   logic                           any_serve;
   logic [pfba_pkg::PAGE_W-1:0]    hit_page;
   logic                           can_open;

   // saturate to the page size
   assign bpp_eff = (page_blocks > pfba_pkg::BPP_W'(pfba_pkg::MAX_BLOCKS_PER_PAGE)) ?
                    pfba_pkg::BPP_W'(pfba_pkg::MAX_BLOCKS_PER_PAGE) : page_blocks;

   always_comb begin
      for (int p = 0; p < pfba_pkg::MAX_PAGES; p++) begin
         can_serve[p] = (pfba_pkg::OPEN_W'(p) < open_ff) &&
                        (head_valid_ff[p] || (count_ff[p] < bpp_eff));
      end
   end

   // lowest serving page wins
   always_comb begin
      hit_page = '0;
      for (int p = pfba_pkg::MAX_PAGES - 1; p >= 0; p--) begin
         if (can_serve[p]) begin
            hit_page = pfba_pkg::PAGE_W'(p);
         end
      end
   end

   assign any_serve = |can_serve;
   assign can_open  = (open_ff < pfba_pkg::OPEN_W'(pfba_pkg::MAX_PAGES)) && (bpp_eff != '0);

   always_comb begin
      plan = '0;
      if (opcode == pfba_pkg::OP_ALLOC) begin
         if (any_serve) begin
            plan.ok   = 1'b1;
            plan.page = hit_page;
            if (head_valid_ff[hit_page]) begin
               plan.pop  = 1'b1;
               plan.slot = head_ff[hit_page];
            end else begin
               plan.fresh = 1'b1;
               plan.slot  = count_ff[hit_page][pfba_pkg::SLOT_W-1:0];
            end
         end else if (can_open) begin
            plan.ok        = 1'b1;
            plan.open_page = 1'b1;
            plan.page      = open_ff[pfba_pkg::PAGE_W-1:0];
         end
      end else begin
         if ((pfba_pkg::OPEN_W'(free_page) < open_ff) &&
             (pfba_pkg::BPP_W'(free_slot) < bpp_eff)) begin
            plan.ok   = 1'b1;
            plan.push = 1'b1;
            plan.page = free_page;
            plan.slot = free_slot;
            plan.link = {head_valid_ff[free_page], head_ff[free_page]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         open_ff       <= pfba_pkg::OPEN_W'(1);
         for (int p = 0; p < pfba_pkg::MAX_PAGES; p++) begin
            count_ff[p] <= '0;
         end
      end else begin
         if (accept && plan.fresh) begin
            count_ff[plan.page] <= count_ff[plan.page] + pfba_pkg::BPP_W'(1);
         end
         if (accept && plan.open_page) begin
            open_ff                  <= open_ff + pfba_pkg::OPEN_W'(1);
            count_ff[plan.page]      <= pfba_pkg::BPP_W'(1);
            head_valid_ff[plan.page] <= 1'b0;
         end
         if (accept && plan.push) begin
            head_valid_ff[plan.page] <= 1'b1;
         end
         if (wb.valid) begin
            head_valid_ff[wb.page] <= wb.link[pfba_pkg::SLOT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && plan.push) begin
         head_ff[plan.page] <= plan.slot;
      end
      if (wb.valid) begin
         head_ff[wb.page] <= wb.link[pfba_pkg::SLOT_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/pfba_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "paged_fixed_block_allocator_top_defines.svh"

module pfba_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ok,
   input wire logic [pfba_pkg::PAGE_W-1:0]     rsp_page,
   input wire logic [pfba_pkg::SLOT_W-1:0]     rsp_slot,
   input wire logic [pfba_pkg::OFFSET_W-1:0]   rsp_byte_offset
);

   // every request beat gets its response on the next cycle
   `PFBA_ASSERT_NEXT(a_rsp_follows_req, start && !busy, rsp_valid, "missing response beat")

   // a response beat is never followed by another without a request
   `PFBA_ASSERT_NEXT(a_single_rsp, rsp_valid, !rsp_valid, "repeated response beat")

   // the block is busy only while its response is out
   `PFBA_ASSERT_NOW(a_busy_means_rsp, busy, rsp_valid, "busy with no response beat")

   // failed beats carry a zero handle
   `PFBA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_ok,
      (rsp_page == '0) && (rsp_slot == '0) && (rsp_byte_offset == '0),
      "failed response with nonzero handle")

endmodule

bind paged_fixed_block_allocator_top pfba_checker u_pfba_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import pfba_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int STALL_LIMIT = 1000;   // cycles with no beat on any channel
   localparam int SETTLE      = 4;
   localparam int REPORT_MAX  = 10;

   // indexes past the register list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(15);

   typedef struct packed {
      logic                ok;
      logic [PAGE_W-1:0]   page;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] byte_offset;
   } blk_reply_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [SLOT_W-1:0] slot;
   } blk_handle_type;

   // block ports, every input known from time zero
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  start         = 1'b0;
   logic                  req_opcode    = OP_ALLOC;
   logic [PAGE_W-1:0]     req_free_page = '0;
   logic [SLOT_W-1:0]     req_free_slot = '0;
   logic                  csr_valid     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic                  rsp_ok;
   logic [PAGE_W-1:0]     rsp_page;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [OFFSET_W-1:0]   rsp_byte_offset;
   logic                  csr_ready;

   // allocator shadow: config, per-page list heads and fresh counts, link store
   logic [BPP_W-1:0]   cfg_bpp;
   logic [BSIZE_W-1:0] cfg_bsize;
   logic               head_valid [MAX_PAGES];
   logic [SLOT_W-1:0]  head_slot  [MAX_PAGES];
   int unsigned        fresh_cnt  [MAX_PAGES];
   logic               link_valid [RAM_DEPTH];
   logic [SLOT_W-1:0]  link_slot  [RAM_DEPTH];
   bit                 on_list    [RAM_DEPTH];   // slot currently sits on its page list
   int unsigned        open_pages;

   blk_reply_type  reply_q [$];   // replies owed by the block, oldest first
   blk_handle_type live_q  [$];   // blocks handed out and not yet given back
   int unsigned err_cnt  = 0;
   int unsigned idle_run = 0;
   bit          no_gaps  = 1'b0;

   paged_fixed_block_allocator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_free_page   (req_free_page),
      .req_free_slot   (req_free_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_page        (rsp_page),
      .rsp_slot        (rsp_slot),
      .rsp_byte_offset (rsp_byte_offset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // ------------------------------------------------------------------
   // allocator shadow
   // ------------------------------------------------------------------

   task automatic shadow_reset();
      cfg_bpp    = BPP_RESET;
      cfg_bsize  = BSIZE_RESET;
      open_pages = 1;
      for (int p = 0; p < MAX_PAGES; p++) begin
         head_valid[p] = 1'b0;
         head_slot[p]  = '0;
         fresh_cnt[p]  = 0;
      end
      for (int a = 0; a < RAM_DEPTH; a++) on_list[a] = 1'b0;
   endtask

   // register values above the page size saturate
   function automatic int unsigned usable_blocks();
      return (cfg_bpp > MAX_BLOCKS_PER_PAGE) ? MAX_BLOCKS_PER_PAGE : int'(cfg_bpp);
   endfunction

   function automatic blk_reply_type granted(int unsigned pg, int unsigned sl);
      blk_reply_type r;
      logic [31:0]   prod;
      prod          = sl * cfg_bsize;
      r.ok          = 1'b1;
      r.page        = PAGE_W'(pg);
      r.slot        = SLOT_W'(sl);
      r.byte_offset = prod[OFFSET_W-1:0];   // wraps at 18 bits
      return r;
   endfunction

   // first open page that can serve: its list head, else its next fresh slot
   function automatic blk_reply_type predict_alloc();
      int unsigned bpp;
      int unsigned at;
      int unsigned sl;
      bpp = usable_blocks();
      for (int unsigned pg = 0; pg < open_pages; pg++) begin
         if (head_valid[pg]) begin
            sl             = head_slot[pg];
            at             = pg * MAX_BLOCKS_PER_PAGE + sl;
            on_list[at]    = 1'b0;
            head_slot[pg]  = link_slot[at];
            head_valid[pg] = link_valid[at];
            return granted(pg, sl);
         end
         if (fresh_cnt[pg] < bpp) begin
            sl            = fresh_cnt[pg];
            fresh_cnt[pg] = sl + 1;
            return granted(pg, sl);
         end
      end
      // every open page full: open the next one and hand out its slot 0
      if (open_pages < MAX_PAGES && bpp > 0) begin
         head_valid[open_pages] = 1'b0;
         fresh_cnt[open_pages]  = 1;
         open_pages++;
         return granted(open_pages - 1, 0);
      end
      return '0;
   endfunction

   // push onto the page list, no check that the slot is already free
   function automatic blk_reply_type predict_free(logic [PAGE_W-1:0] pg,
                                                  logic [SLOT_W-1:0] sl);
      int unsigned at;
      if (int'(pg) >= open_pages || sl >= usable_blocks()) return '0;
      at             = int'(pg) * MAX_BLOCKS_PER_PAGE + int'(sl);
      link_slot[at]  = head_slot[pg];
      link_valid[at] = head_valid[pg];
      on_list[at]    = 1'b1;
      head_slot[pg]  = sl;
      head_valid[pg] = 1'b1;
      return granted(pg, sl);
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // one request beat; start stays up unless a gap follows
   task automatic issue(logic op, logic [PAGE_W-1:0] pg, logic [SLOT_W-1:0] sl,
                        output blk_reply_type rep);
      int unsigned gap;
      @(negedge clock);
      start         <= 1'b1;
      req_opcode    <= op;
      req_free_page <= pg;
      req_free_slot <= sl;
      @(posedge clock);
      while (busy) @(posedge clock);
      rep = (op == OP_FREE) ? predict_free(pg, sl) : predict_alloc();
      reply_q = {reply_q, rep};
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // page and slot fields are don't-care on allocate, so they get noise
   task automatic alloc_one();
      blk_reply_type  rep;
      blk_handle_type h;
      issue(OP_ALLOC, PAGE_W'($urandom), SLOT_W'($urandom), rep);
      if (rep.ok) begin
         h.page = rep.page;
         h.slot = rep.slot;
         live_q = {live_q, h};
      end
   endtask

   task automatic free_block(logic [PAGE_W-1:0] pg, logic [SLOT_W-1:0] sl);
      blk_reply_type rep;
      // pushing a slot that is already listed closes a loop on that page for good,
      // so that only happens in the dedicated test at the end
      if (int'(pg) < open_pages && sl < usable_blocks() && on_list[{pg, sl}])
         alloc_one();
      else
         issue(OP_FREE, pg, sl, rep);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PAGE_BLOCKS: cfg_bpp = val[BPP_W-1:0];
         CSR_BLOCK_BYTES: cfg_bsize = val[BSIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop start and hold off until every owed reply has come back
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (reply_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset config: fresh slots, free of a never-used slot, pop, handle outside open pages
   task automatic test_defaults();
      alloc_one();
      alloc_one();
      free_block(3'd0, 6'd63);
      alloc_one();
      free_block(3'd0, 6'd1);
      alloc_one();
      free_block(3'd7, 6'd63);
   endtask

   // saturating page size, dropped indexes, block size at its maximum
   task automatic test_reg_extremes();
      wait_idle();
      write_reg(CSR_PAGE_BLOCKS, '1);
      write_reg(CSR_SPARE_LO, CSR_DATA_W'(3));
      write_reg(CSR_SPARE_HI, '1);
      write_reg(CSR_BLOCK_BYTES, '1);
      alloc_one();
      free_block(3'd0, 6'd63);
      alloc_one();   // 63 * 8191 wraps the offset
   endtask

   // page size cut at run time, every page opened, allocate with nothing left
   task automatic test_page_fill();
      free_block(3'd0, 6'd40);
      wait_idle();
      write_reg(CSR_PAGE_BLOCKS, CSR_DATA_W'(1));
      write_reg(CSR_BLOCK_BYTES, CSR_DATA_W'(4));
      repeat (9) alloc_one();   // slot 40 still pops, then pages open up to the last
      free_block(3'd1, 6'd1);   // slot past the page size
      free_block(3'd3, 6'd0);
      alloc_one();              // later page served by its list
   endtask

   // zero page size: no fresh slot and no free accepted
   task automatic test_zero_blocks();
      wait_idle();
      write_reg(CSR_PAGE_BLOCKS, CSR_DATA_W'(0));
      free_block(3'd2, 6'd0);
      alloc_one();
   endtask

   // mostly balanced alloc/free of live blocks, some random frees as noise
   task automatic run_mixed(int unsigned n, int unsigned alloc_pct,
                            logic [CSR_DATA_W-1:0] bpp, logic [CSR_DATA_W-1:0] bsize);
      blk_handle_type h;
      int unsigned    pick;
      int unsigned    r;
      wait_idle();
      write_reg(CSR_PAGE_BLOCKS, bpp);
      write_reg(CSR_BLOCK_BYTES, bsize);
      for (int unsigned k = 0; k < n; k++) begin
         no_gaps = ((k / 40) % 3) == 1;   // every third stretch runs flat out
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            alloc_one();
         end else if (r < 92 && live_q.size() != 0) begin
            pick = $urandom_range(live_q.size() - 1);
            h    = live_q[pick];
            live_q.delete(pick);
            free_block(h.page, h.slot);
         end else begin
            free_block(PAGE_W'($urandom), SLOT_W'($urandom));
         end
         if ($urandom_range(149) == 0) wait_idle();
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random_mix();
      run_mixed(250, 65, CSR_DATA_W'(64), CSR_DATA_W'(16));
      run_mixed(200, 60, CSR_DATA_W'(2), CSR_DATA_W'(4));
      run_mixed(230, 50, CSR_DATA_W'(64), CSR_DATA_W'(4096));
      wait_idle();
      write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      run_mixed(200, 55, CSR_DATA_W'($urandom_range(64, 1)),
                CSR_DATA_W'($urandom_range(4096, 4)));
      run_mixed(100, 40, CSR_DATA_W'(0), CSR_DATA_W'(4));
      run_mixed(220, 70, CSR_DATA_W'(100), CSR_DATA_W'(8191));
   endtask

   // same slot freed twice: accepted, and the page keeps handing it out
   task automatic test_double_free();
      blk_reply_type rep;
      wait_idle();
      write_reg(CSR_PAGE_BLOCKS, CSR_DATA_W'(64));
      write_reg(CSR_BLOCK_BYTES, CSR_DATA_W'(16));
      issue(OP_FREE, 3'd0, 6'd5, rep);
      issue(OP_FREE, 3'd0, 6'd5, rep);
      repeat (3) alloc_one();
   endtask

   // ------------------------------------------------------------------
   // reply checker: every reply beat against the oldest owed reply
   // ------------------------------------------------------------------
   always @(posedge clock) begin : reply_check
      blk_reply_type want;
      if (!reset && rsp_valid) begin
         if (reply_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
               $display("tb: unexpected reply: ok=%0d page=%0d slot=%0d off=%0d",
                        rsp_ok, rsp_page, rsp_slot, rsp_byte_offset);
         end else begin
            want = reply_q.pop_front();
            if (rsp_ok !== want.ok || rsp_page !== want.page || rsp_slot !== want.slot ||
                rsp_byte_offset !== want.byte_offset) begin
               err_cnt++;
               if (err_cnt <= REPORT_MAX) begin
                  $write("tb: reply mismatch: want ok=%0d page=%0d slot=%0d off=%0d",
                         want.ok, want.page, want.slot, want.byte_offset);
                  $display(", got ok=%0d page=%0d slot=%0d off=%0d",
                           rsp_ok, rsp_page, rsp_slot, rsp_byte_offset);
               end
            end
         end
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else if (idle_run == STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      shadow_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_reg_extremes();
      test_page_fill();
      test_zero_blocks();
      test_random_mix();
      test_double_free();

      wait_idle();
      if (err_cnt == 0 && reply_q.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
